FILE: design/asdz_pkg.sv
// ----------------------------------------------------------------------------
// asdz_pkg: shared types and constants for the analog stick polar unit
// Holds the pipeline word layout, stage map and CORDIC arctangent table.
// ----------------------------------------------------------------------------
package asdz_pkg;

    // Register index map of the configuration port
    localparam logic CFG_DEAD_ZONE  = 1'b0;
    localparam logic CFG_FULL_RANGE = 1'b1;

    localparam logic [6:0] DEAD_ZONE_RST  = 7'd48;
    localparam logic [7:0] FULL_RANGE_RST = 8'd80;

    // Stage map: 0 centre/shrink, 1 square sum + pre-rotation,
    // 2 scale (and first CORDIC step), 3..18 root bits, 19..34 quotient bits
    localparam int CORDIC_STEPS = 17;
    localparam int CORDIC_FIRST = 2;
    localparam int SQRT_FIRST   = 3;
    localparam int SQRT_STEPS   = 16;
    localparam int DIV_FIRST    = SQRT_FIRST + SQRT_STEPS;
    localparam int DIV_STEPS    = 16;
    localparam int NSTAGE       = DIV_FIRST + DIV_STEPS;

    localparam int XY_W = 27;
    localparam int Z_W  = 20;
    localparam int Z_FRAC = 16;

    localparam logic signed [Z_W-1:0] Q16_HALF_PI = 20'sd102944;
    localparam int Q16_PI     = 205887;
    localparam int Q16_TWO_PI = 411775;

    localparam logic [16:0] ATAN_TAB [CORDIC_STEPS] = '{
        17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047,
        17'd1024, 17'd512, 17'd256, 17'd128, 17'd64, 17'd32, 17'd16,
        17'd8, 17'd4, 17'd2, 17'd1
    };

    localparam logic [31:0] SQ_SCALE = 32'd65025;

    typedef struct packed {
        logic signed [8:0]      cx;
        logic signed [8:0]      cy;
        logic signed [8:0]      ax;
        logic signed [8:0]      ay;
        logic                   cy_nz;
        logic                   s_nz;
        logic [15:0]            s;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [31:0]            n;
        logic [31:0]            res;
        logic [15:0]            d;
        logic [7:0]             rem;
    } pipe_t;

endpackage

FILE: design/analog_stick_polar_deadzone_unit.sv
// ----------------------------------------------------------------------------
// analog_stick_polar_deadzone_unit: stick sample to angle and magnitude
// Dead-zone shrink, exact integer root, divide and CORDIC arctangent.
// ----------------------------------------------------------------------------
// One word in, one word out. A stick sample (x, y bytes, centre 128) passes
// through the pipe and leaves as a signed angle in radians (2^ANGLE_FRAC_BITS
// per radian), a saturated 0..255 magnitude and a centred flag. The unit is a
// 36-register pipeline: one stage for centring and dead-zone shrink, one for
// the square sum and quadrant pre-rotation, one for the 65025 scale, sixteen
// one-bit square root stages, sixteen one-bit restoring divide stages, and an
// output register; the 17 CORDIC vectoring steps ride the scale and root stages.
// A new word is taken every cycle; the whole pipe holds while the output word
// waits for m_ready. Write dead_zone and full_range only while the pipe is
// empty.
module analog_stick_polar_deadzone_unit #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_stick_x,
    input  logic [7:0]         s_stick_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_stick_angle,
    output logic [7:0]         m_stick_magnitude,
    output logic               m_centred_flag
);

    localparam int SH = asdz_pkg::Z_FRAC - ANGLE_FRAC_BITS;
    localparam int PI_QI  = (asdz_pkg::Q16_PI + (1 << (SH - 1))) >> SH;
    localparam int TPI_QI = (asdz_pkg::Q16_TWO_PI + (1 << (SH - 1))) >> SH;
    localparam logic signed [asdz_pkg::Z_W-1:0] PI_Q  = asdz_pkg::Z_W'(PI_QI);
    localparam logic signed [asdz_pkg::Z_W-1:0] TPI_Q = asdz_pkg::Z_W'(TPI_QI);
    localparam logic signed [asdz_pkg::Z_W-1:0] RND   = asdz_pkg::Z_W'(1 << (SH - 1));

    logic [6:0] dead_zone_reg;
    logic [7:0] full_range_reg;

    asdz_pkg::pipe_t p_reg  [asdz_pkg::NSTAGE];
    asdz_pkg::pipe_t p_next [asdz_pkg::NSTAGE];
    logic            v_reg  [asdz_pkg::NSTAGE];

    logic                     m_valid_reg;
    logic signed [15:0]       angle_reg, angle_next;
    logic [7:0]               mag_reg, mag_next;
    logic                     flag_reg;
    logic                     adv;

    // Advance the whole pipe unless the output word is stalled
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_zone_reg  <= asdz_pkg::DEAD_ZONE_RST;
            full_range_reg <= asdz_pkg::FULL_RANGE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                asdz_pkg::CFG_DEAD_ZONE:  dead_zone_reg  <= cfg_data[6:0];
                asdz_pkg::CFG_FULL_RANGE: full_range_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic signed [8:0] shrink(logic signed [8:0] c, logic [6:0] dz);
        logic signed [8:0] sdz;
        sdz = $signed({2'b00, dz});
        if (c > sdz)       return c - sdz;
        else if (c < -sdz) return c + sdz;
        else               return 9'sd0;
    endfunction

    // One pipeline step; k is an elaboration constant, so each instance
    // keeps only the branch of its own stage.
    function automatic asdz_pkg::pipe_t step(asdz_pkg::pipe_t p, int k,
                                             logic [7:0] fr);
        asdz_pkg::pipe_t q;
        logic signed [17:0]             sq;
        logic signed [9:0]              xn, yn;
        logic signed [asdz_pkg::XY_W-1:0] xw, yw, xs, ys;
        logic [31:0]                    bitv, trial;
        logic [8:0]                     r2;
        int                             i;
        q = p;
        if (k == 1) begin
            sq      = p.ax * p.ax + p.ay * p.ay;
            q.s     = sq[15:0];
            q.s_nz  = (sq != 18'sd0);
            q.cy_nz = (p.cy != 9'sd0);
            xn = 10'(p.cy);
            yn = -10'(p.cx);
            xw = asdz_pkg::XY_W'(xn) <<< 16;
            yw = asdz_pkg::XY_W'(yn) <<< 16;
            if (xw < 0) begin
                if (yw >= 0) begin
                    q.x = yw; q.y = -xw; q.z = asdz_pkg::Q16_HALF_PI;
                end else begin
                    q.x = -yw; q.y = xw; q.z = -asdz_pkg::Q16_HALF_PI;
                end
            end else begin
                q.x = xw; q.y = yw; q.z = '0;
            end
        end
        if (k == 2) begin
            q.n   = {16'd0, p.s} * asdz_pkg::SQ_SCALE;
            q.res = '0;
        end
        if (k >= asdz_pkg::CORDIC_FIRST &&
            k < asdz_pkg::CORDIC_FIRST + asdz_pkg::CORDIC_STEPS) begin
            i  = k - asdz_pkg::CORDIC_FIRST;
            xs = p.x >>> i;
            ys = p.y >>> i;
            if (p.y > 0) begin
                q.x = p.x + ys; q.y = p.y - xs;
                q.z = p.z + asdz_pkg::Z_W'(asdz_pkg::ATAN_TAB[i]);
            end else begin
                q.x = p.x - ys; q.y = p.y + xs;
                q.z = p.z - asdz_pkg::Z_W'(asdz_pkg::ATAN_TAB[i]);
            end
        end
        if (k >= asdz_pkg::SQRT_FIRST && k < asdz_pkg::DIV_FIRST) begin
            i     = k - asdz_pkg::SQRT_FIRST;
            bitv  = 32'd1 << (30 - 2 * i);
            trial = p.res + bitv;
            if (p.n >= trial) begin
                q.n   = p.n - trial;
                q.res = (p.res >> 1) + bitv;
            end else begin
                q.res = p.res >> 1;
            end
            if (k == asdz_pkg::DIV_FIRST - 1) begin
                q.d   = q.res[15:0];
                q.rem = '0;
            end
        end
        if (k >= asdz_pkg::DIV_FIRST) begin
            r2 = {p.rem, p.d[15]};
            if (r2 >= {1'b0, fr}) begin
                q.rem = 8'(r2 - {1'b0, fr});
                q.d   = {p.d[14:0], 1'b1};
            end else begin
                q.rem = r2[7:0];
                q.d   = {p.d[14:0], 1'b0};
            end
        end
        return q;
    endfunction

    // Stage 0: center both axes and shrink by the dead zone
    always_comb begin
        p_next[0]    = p_reg[0];
        p_next[0].cx = $signed({1'b0, s_stick_x}) - 9'sd128;
        p_next[0].cy = $signed({1'b0, s_stick_y}) - 9'sd128;
        p_next[0].ax = shrink(p_next[0].cx, dead_zone_reg);
        p_next[0].ay = shrink(p_next[0].cy, dead_zone_reg);
    end

    for (genvar k = 1; k < asdz_pkg::NSTAGE; k++) begin : g_stage
        always_comb p_next[k] = step(p_reg[k-1], k, full_range_reg);
    end

    for (genvar k = 0; k < asdz_pkg::NSTAGE; k++) begin : g_reg
        always_ff @(posedge aclk) begin
            if (adv) begin
                p_reg[k] <= p_next[k];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (adv) begin
                v_reg[k] <= (k == 0) ? s_valid : v_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // Output stage: saturate magnitude, round and bound the angle
    always_comb begin
        asdz_pkg::pipe_t            pl;
        logic signed [asdz_pkg::Z_W-1:0] a;
        pl = p_reg[asdz_pkg::NSTAGE-1];
        if (full_range_reg == 8'd0) begin
            mag_next = pl.s_nz ? 8'd255 : 8'd0;
        end else begin
            mag_next = (pl.d > 16'd255) ? 8'd255 : pl.d[7:0];
        end
        a = (pl.z + RND) >>> SH;
        if (a < -PI_Q) a = a + TPI_Q;
        if (a > PI_Q)  a = PI_Q;
        if (a < -PI_Q) a = -PI_Q;
        if (mag_next != 8'd0 && pl.cy_nz) begin
            angle_next = a[15:0];
        end else begin
            angle_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v_reg[asdz_pkg::NSTAGE-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            angle_reg <= angle_next;
            mag_reg   <= mag_next;
            flag_reg  <= (mag_next == 8'd0);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_stick_angle     = angle_reg;
    assign m_stick_magnitude = mag_reg;
    assign m_centred_flag    = flag_reg;

endmodule
